/* hdl/ipv4_rhc_pkg.sv */
`timescale 1ns / 1ps

package ipv4_rhc_pkg;

    // width of the saturating byte counter
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    // fixed header size in bytes
    localparam int HDR_BYTES = 20;
    localparam int POS_BITS  = 5;

    // header byte offsets
    localparam logic [POS_BITS-1:0] POS_VERSION   = POS_BITS'(0);
    localparam logic [POS_BITS-1:0] POS_LEN_HI    = POS_BITS'(2);
    localparam logic [POS_BITS-1:0] POS_LEN_LO    = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_PROTOCOL  = POS_BITS'(9);
    localparam logic [POS_BITS-1:0] POS_CSUM_HI   = POS_BITS'(10);
    localparam logic [POS_BITS-1:0] POS_CSUM_LO   = POS_BITS'(11);
    localparam logic [POS_BITS-1:0] POS_SRC_FIRST = POS_BITS'(12);
    localparam logic [POS_BITS-1:0] POS_SRC_LAST  = POS_BITS'(15);
    localparam logic [POS_BITS-1:0] POS_DST_FIRST = POS_BITS'(16);
    localparam logic [POS_BITS-1:0] POS_DST_LAST  = POS_BITS'(19);

    localparam logic [3:0] HDR_VERSION_V4 = 4'd4;

    // verdict codes
    localparam logic [2:0] STATUS_ACCEPT    = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [2:0] STATUS_BAD_HDR   = 3'd2;
    localparam logic [2:0] STATUS_BAD_CSUM  = 3'd3;
    localparam logic [2:0] STATUS_NOT_OURS  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [15:0] payload_length;
    } out_item_t;

    // header state as it stands after the current byte
    typedef struct packed {
        logic [LENGTH_BITS-1:0] count;
        logic [15:0]            sum;
        logic [3:0]             version;
        logic [15:0]            total_length;
        logic [15:0]            checksum;
        logic [7:0]             protocol;
        logic [31:0]            src;
        logic [31:0]            dst;
    } hdr_t;

endpackage

/* hdl/ipv4_rhc_parse.sv */
`timescale 1ns / 1ps

module ipv4_rhc_parse
    import ipv4_rhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_item_t item,
    output hdr_t     hdr_next
);

    logic [LENGTH_BITS-1:0] count_reg;
    logic [15:0]            sum_reg;
    logic [7:0]             hold_reg;
    logic [3:0]             version_reg;
    logic [15:0]            total_reg;
    logic [15:0]            checksum_reg;
    logic [7:0]             protocol_reg;
    logic [31:0]            src_reg;
    logic [31:0]            dst_reg;

    logic [7:0]             hold_next;
    logic [POS_BITS-1:0]    pos;
    logic                   in_header;
    logic [16:0]            word_sum;
    logic [15:0]            folded_sum;

    assign in_header  = count_reg < LENGTH_BITS'(HDR_BYTES);
    assign pos        = count_reg[POS_BITS-1:0];
    assign word_sum   = {1'b0, sum_reg} + {1'b0, hold_reg, item.data_byte};
    // end-around carry
    assign folded_sum = word_sum[15:0] + 16'(word_sum[16]);

    always_comb
    begin
        hdr_next.count        = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        hdr_next.sum          = sum_reg;
        hdr_next.version      = version_reg;
        hdr_next.total_length = total_reg;
        hdr_next.checksum     = checksum_reg;
        hdr_next.protocol     = protocol_reg;
        hdr_next.src          = src_reg;
        hdr_next.dst          = dst_reg;
        hold_next             = hold_reg;
        if (in_header)
        begin
            if (!pos[0])
            begin
                hold_next = item.data_byte;
            end
            else if (pos != POS_CSUM_LO)
            begin
                hdr_next.sum = folded_sum;
            end
            case (pos)
                POS_VERSION:  hdr_next.version = item.data_byte[7:4];
                POS_LEN_HI:   hdr_next.total_length = {item.data_byte, 8'h00};
                POS_LEN_LO:   hdr_next.total_length = {total_reg[15:8], item.data_byte};
                POS_PROTOCOL: hdr_next.protocol = item.data_byte;
                POS_CSUM_HI:  hdr_next.checksum = {item.data_byte, 8'h00};
                POS_CSUM_LO:  hdr_next.checksum = {checksum_reg[15:8], item.data_byte};
                default:      ;
            endcase
            if (pos inside {[POS_SRC_FIRST:POS_SRC_LAST]})
            begin
                hdr_next.src = {src_reg[23:0], item.data_byte};
            end
            else if (pos inside {[POS_DST_FIRST:POS_DST_LAST]})
            begin
                hdr_next.dst = {dst_reg[23:0], item.data_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            hold_reg     <= '0;
            version_reg  <= '0;
            total_reg    <= '0;
            checksum_reg <= '0;
            protocol_reg <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                // packet done, start fresh
                count_reg    <= '0;
                sum_reg      <= '0;
                hold_reg     <= '0;
                version_reg  <= '0;
                total_reg    <= '0;
                checksum_reg <= '0;
                protocol_reg <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
            end
            else
            begin
                count_reg    <= hdr_next.count;
                sum_reg      <= hdr_next.sum;
                hold_reg     <= hold_next;
                version_reg  <= hdr_next.version;
                total_reg    <= hdr_next.total_length;
                checksum_reg <= hdr_next.checksum;
                protocol_reg <= hdr_next.protocol;
                src_reg      <= hdr_next.src;
                dst_reg      <= hdr_next.dst;
            end
        end
    end

endmodule

/* hdl/ipv4_rhc_verdict.sv */
`timescale 1ns / 1ps

module ipv4_rhc_verdict
    import ipv4_rhc_pkg::*;
(
    input  hdr_t        hdr,
    input  logic [31:0] local_ip,
    output out_item_t   result
);

    logic [15:0] count_ext;

    assign count_ext = 16'(hdr.count);

    always_comb
    begin
        result = '0;
        if (count_ext < 16'(HDR_BYTES) || hdr.total_length < 16'(HDR_BYTES))
        begin
            result.status = STATUS_TOO_SHORT;
        end
        else if (hdr.version != HDR_VERSION_V4 || hdr.total_length > count_ext)
        begin
            result.status = STATUS_BAD_HDR;
        end
        else if (hdr.checksum != ~hdr.sum)
        begin
            result.status = STATUS_BAD_CSUM;
        end
        else if (hdr.dst != local_ip)
        begin
            result.status = STATUS_NOT_OURS;
        end
        else
        begin
            result.status         = STATUS_ACCEPT;
            result.protocol       = hdr.protocol;
            result.source_ip      = hdr.src;
            result.payload_length = hdr.total_length - 16'(HDR_BYTES);
        end
    end

endmodule

/* hdl/ipv4_receive_header_check.sv */
`timescale 1ns / 1ps
// result path: a byte transfer fills the input register, and the verdict of a last byte
//   is computed from there and captured in the result register, from which it transfers
// throughput: one byte per cycle, set by the single pass from input to result register;
//   a last byte waits only while a verdict sits stalled in the result register
// reset: rst_n clears all control and header state and local_ip to zero, no clearing pass
module ipv4_receive_header_check
    import ipv4_rhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte stream side
    input  logic        byte_valid,
    output logic        byte_stall,
    input  in_item_t    byte_item,
    // verdict side
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result_item,
    // local address register
    input  logic        cfg_write,
    input  logic [31:0] cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [31:0] local_ip_reg;

    logic        slot_free;
    logic        advance;
    hdr_t        hdr_next;
    out_item_t   verdict_next;

    // result register can take a new verdict this cycle
    assign slot_free  = !out_valid_reg || !result_stall;
    // plain bytes always move on; a last byte waits for room in the result register
    assign advance    = in_valid_reg && (!in_item_reg.last_byte || slot_free);
    // the input register refills whenever its content moves on or it is empty
    assign byte_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall)
        begin
            in_item_reg <= byte_item;
        end
    end

    // per-packet header capture and checksum sum
    ipv4_rhc_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (in_item_reg),
        .hdr_next (hdr_next)
    );

    // checks in priority order on the state after the last byte
    ipv4_rhc_verdict u_verdict (
        .hdr      (hdr_next),
        .local_ip (local_ip_reg),
        .result   (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (cfg_write)
        begin
            local_ip_reg <= cfg_data;
        end
    end

    // result register, held while the far side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_item_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
        begin
            out_item_reg <= verdict_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule
